// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files; clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/olir_pkg.sv
// Package for the ordered list: sizes, op and status codes, cell control type.
`timescale 1ns / 1ps
`default_nettype none

package olir_pkg;

  localparam int DEPTH      = 64;
  localparam int WORD_WIDTH = 32;
  localparam int OP_W       = 3;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int OUT_W      = 32;
  localparam int ST_W       = 2;

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 3'd0,
    OP_APPEND = 3'd1,
    OP_DROP   = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Broadcast to every cell in the chain
  typedef struct packed {
    logic  ins;
    logic  app;
    logic  rem;
    cnt_t  index;
    cnt_t  count;
    word_t value;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/olir_if.sv
// Request and response channel interfaces of the ordered list.
`timescale 1ns / 1ps
`default_nettype none

interface list_req_if;
  import olir_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [CNT_W-1:0]      index;
  logic [OUT_W-1:0]      value;

  modport source (output valid, op, index, value, input ready);
  modport sink   (input valid, op, index, value, output ready);
endinterface

interface list_rsp_if;
  import olir_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OUT_W-1:0]      read_value;
  logic [ST_W-1:0]       status;
  logic [CNT_W-1:0]      count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/olir_cell.sv
// One storage cell of the list chain: holds one word, loads, or takes a neighbor's word.
`timescale 1ns / 1ps
`default_nettype none

module olir_cell import olir_pkg::*; (
  input  logic      clk_i,
  input  cnt_t      pos_i,
  input  cell_ctl_t ctl_i,
  input  word_t     left_i,
  input  word_t     right_i,
  output word_t     data_o,
  output word_t     rd_o
);

  word_t data_q, data_d;
  logic  hit;

  assign hit = (pos_i == ctl_i.index);

  // Pick the next word: new value, shift up from the left, shift down from the right
  always_comb begin
    data_d = data_q;
    if (ctl_i.app && (pos_i == ctl_i.count)) begin
      data_d = ctl_i.value;
    end else if (ctl_i.ins && hit) begin
      data_d = ctl_i.value;
    end else if (ctl_i.ins && (pos_i > ctl_i.index) && (pos_i <= ctl_i.count)) begin
      data_d = left_i;
    end else if (ctl_i.rem && (pos_i >= ctl_i.index)
                 && ((pos_i + cnt_t'(1)) < ctl_i.count)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = hit ? data_q : '0;

endmodule

`default_nettype wire

// File: hw/rtl/ordered_list_insert_remove.sv
// Top level of the ordered list: request decode, count, cell chain and response register.
//
// Usage: requests arrive on req_i (op, index, value) and each produces exactly
// one response on rsp_o (read_value, status, count). A transfer happens when
// valid and ready are both high.
// The response is valid in the cycle after the request transfer.
// Throughput: one request per cycle while the receiver takes responses; the
// insert or remove shift is done by all cells in parallel at the transfer,
// each cell taking its neighbor's word.
// A read selects the addressed cell through a one-hot AND-OR over the chain.
// Stall: while a response waits untaken, req_i.ready is low, so no request
// is lost; the response register holds its contents.
// Reset: the count clears to zero and no response is pending; cell contents
// are left as they are and are only read after being written.
// Full list: append and an in-range insert report full and leave storage unchanged.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_remove import olir_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  list_req_if.sink        req_i,
  list_rsp_if.source      rsp_o
);

  cnt_t           count_q, count_d;
  logic           rsp_valid_q;
  logic [OUT_W-1:0] rd_value_q;
  status_e        status_q;
  status_e        status_d;
  logic           xfer;
  logic           read_ok;
  logic           grow;
  logic           shrink;
  cell_ctl_t      ctl;
  word_t          cell_data [DEPTH];
  word_t          cell_rd   [DEPTH];
  word_t          rd_word;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign xfer        = req_i.valid && req_i.ready;

  // Decode the request against the current count
  always_comb begin
    status_d = ST_OK;
    read_ok  = 1'b0;
    grow     = 1'b0;
    shrink   = 1'b0;
    ctl      = '0;
    case (op_e'(req_i.op))
      OP_READ: begin
        if (req_i.index < count_q) read_ok = 1'b1;
        else                       status_d = ST_RANGE;
      end
      OP_APPEND: begin
        if (count_q == cnt_t'(DEPTH)) status_d = ST_FULL;
        else                          grow = 1'b1;
      end
      OP_DROP: begin
        if (count_q == '0) status_d = ST_EMPTY;
        else               shrink = 1'b1;
      end
      OP_INSERT: begin
        if (req_i.index > count_q)         status_d = ST_RANGE;
        else if (count_q == cnt_t'(DEPTH)) status_d = ST_FULL;
        else                               grow = 1'b1;
      end
      OP_REMOVE: begin
        if (req_i.index >= count_q) status_d = ST_RANGE;
        else                        shrink = 1'b1;
      end
      default: status_d = ST_RANGE;
    endcase
    ctl.app   = xfer && grow   && (op_e'(req_i.op) == OP_APPEND);
    ctl.ins   = xfer && grow   && (op_e'(req_i.op) == OP_INSERT);
    ctl.rem   = xfer && shrink && (op_e'(req_i.op) == OP_REMOVE);
    ctl.index = req_i.index;
    ctl.count = count_q;
    ctl.value = req_i.value[WORD_WIDTH-1:0];
  end

  always_comb begin
    count_d = count_q;
    if (xfer && grow)   count_d = count_q + cnt_t'(1);
    if (xfer && shrink) count_d = count_q - cnt_t'(1);
  end

  // Chain of cells, each linked to its two neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end
    olir_cell u_cell (
      .clk_i   (clk_i),
      .pos_i   (cnt_t'(i)),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  // Combine the one-hot read contributions
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Control state: count and response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (xfer)             rsp_valid_q <= 1'b1;
      else if (rsp_o.ready) rsp_valid_q <= 1'b0;
    end
  end

  // Response payload, loaded on each request transfer
  always_ff @(posedge clk_i) begin
    if (xfer) begin
      rd_value_q <= read_ok ? OUT_W'(rd_word) : '0;
      status_q   <= status_d;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_value = rd_value_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.count      = count_q;

  `include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, count_q <= cnt_t'(DEPTH), "count exceeds depth")
  `ASSERT_NEXT(a_rsp_follows, xfer, rsp_valid_q, "no response after request transfer")
  `ASSERT_NEXT(a_stall_holds, rsp_valid_q && !rsp_o.ready, $stable(count_q) && rsp_valid_q, "count moved during stall")
  `ASSERT_NEXT(a_full_keeps, xfer && (status_d == ST_FULL), $stable(count_q), "full request changed count")

endmodule

`default_nettype wire
